// ===== hw/rtl/skf_pkg.sv =====
// ----------------------------------------------------------------------------
// skf_pkg
// Shared types, constants and a rounding helper for the scalar Kalman filter.
// ----------------------------------------------------------------------------
package skf_pkg;

    localparam int VALUE_FRAC = 16;
    localparam int COV_FRAC   = 24;
    localparam int GAIN_FRAC  = 24;
    localparam int W_FRAC     = 16;

    localparam int VAL_W     = 32;
    localparam int COV_W     = 63;
    localparam int GAIN_W    = GAIN_FRAC + 1;
    localparam int ACC_W     = 96;
    localparam int CFG_IDX_W = 3;

    localparam logic [COV_W-1:0]  MAX63    = '1;
    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FRAC;
    localparam logic [31:0]       W_OLD    = 32'd58982;
    localparam logic [31:0]       W_NEW    = 32'd6554;

    localparam logic [VAL_W-1:0] INIT_EST_RST = '0;
    localparam logic [COV_W-1:0] INIT_COV_RST = 63'd16777216;
    localparam logic [COV_W-1:0] Q_RST        = 63'd167772;
    localparam logic [COV_W-1:0] R_RST        = 63'd1677722;
    localparam logic [COV_W-1:0] LIMIT_RST    = 63'd167772160000000000;

    localparam logic [CFG_IDX_W-1:0] REG_INIT_EST = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_COV = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Q        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_R        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ADAPT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 3'd5;

    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW = 2'd1;
    localparam logic [1:0] ERR_DIVERGED = 2'd2;

    localparam logic REQ_RESTART = 1'b1;

    typedef struct packed {
        logic                    req_type;
        logic signed [VAL_W-1:0] value;
    } in_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] estimate;
        logic [GAIN_W-1:0]       gain;
        logic [COV_W-1:0]        covariance;
        logic                    error_held;
        logic [1:0]              error_code;
    } out_t;

    typedef struct packed {
        logic issue;
        logic clear;
        logic accum;
        logic hi;
    } mac_ctrl_t;

    typedef struct packed {
        logic             start;
        logic [COV_W-1:0] num;
        logic [63:0]      den;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [GAIN_FRAC-1:0] quot;
    } div_rsp_t;

    // (v + 2^(n-1)) >> n, saturated to 63 bits
    function automatic logic [COV_W-1:0] rnd_shift(input logic [ACC_W-1:0] v,
                                                   input int unsigned n);
        logic [ACC_W:0] sum;
        logic [ACC_W:0] sh;
        sum = {1'b0, v} + ((ACC_W+1)'(1) << (n - 1));
        sh  = sum >> n;
        if (|sh[ACC_W:COV_W]) begin
            return MAX63;
        end
        return sh[COV_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/scalar_kalman_filter.sv =====
// ----------------------------------------------------------------------------
// scalar_kalman_filter
// Fixed-point scalar Kalman filter with optional adaptive measurement noise.
// ----------------------------------------------------------------------------
// Usage:
//   s_* takes one item: a measurement update or a restart of the estimate.
//   m_* returns one result per item: estimate, gain, covariance and error.
//   cfg_* writes the six setup registers; write them only while idle.
//   An update runs through a sequencer: predict add, gain add, a restoring
//   divide, then products on one shared 32x32 multiplier, each partial
//   product issued in S_MUL and accumulated in S_ACC. Zero noise or a zero
//   sum skips the divide; a restart or a predict overflow goes straight to
//   the output step.
//   s_ready is high only while the sequencer is idle, one item at a time;
//   the next item can be taken in the cycle after a result is loaded.
//   A result waits in the output register while m_ready is low; the next
//   item can be taken meanwhile and holds at the output step until the
//   register frees.
//   Reset loads the filter state from the register reset values.
// ----------------------------------------------------------------------------
module scalar_kalman_filter (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  skf_pkg::in_t                  s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output skf_pkg::out_t                 m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [skf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [skf_pkg::COV_W-1:0]     cfg_data
);
    import skf_pkg::*;

    localparam int SQ_SHIFT = 2 * VALUE_FRAC - COV_FRAC;
    localparam int SQ_RSH   = (SQ_SHIFT > 0) ? SQ_SHIFT : 0;
    localparam int SQ_LSH   = (SQ_SHIFT < 0) ? -SQ_SHIFT : 0;

    typedef enum logic [3:0] {
        S_IDLE, S_PRED, S_SUM, S_DIV, S_MUL, S_ACC, S_FIN, S_CHK, S_OUT
    } state_t;

    typedef enum logic [2:0] {
        G_DELTA, G_COV, G_SQ, G_SM1, G_SM2
    } grp_t;

    state_t state_reg, state_next;
    grp_t   grp_reg, grp_next;
    logic [1:0] opi_reg, opi_next;

    logic [VAL_W-1:0] init_est_reg, init_est_next;
    logic [COV_W-1:0] init_cov_reg, init_cov_next;
    logic [COV_W-1:0] q_reg, q_next;
    logic [COV_W-1:0] meas_reg, meas_next;
    logic             adapt_reg, adapt_next;
    logic [COV_W-1:0] limit_reg, limit_next;

    logic [VAL_W-1:0]  est_reg, est_next;
    logic [COV_W-1:0]  cov_reg, cov_next;
    logic [COV_W-1:0]  r_reg, r_next;
    logic [COV_W-1:0]  var_reg, var_next;
    logic [GAIN_W-1:0] gain_reg, gain_next;
    logic              err_flag_reg, err_flag_next;
    logic [1:0]        err_code_reg, err_code_next;
    logic [COV_W-1:0]  ppred_reg, ppred_next;
    logic [31:0]       mag_reg, mag_next;
    logic              neg_reg, neg_next;
    logic [COV_W-1:0]  sqc_reg, sqc_next;
    logic              m_valid_reg, m_valid_next;
    out_t              m_data_reg, m_data_next;

    mac_ctrl_t        mac_ctrl;
    logic [31:0]      mac_a;
    logic [31:0]      mac_b;
    logic [ACC_W-1:0] acc;
    div_req_t         div_req;
    div_rsp_t         div_rsp;

    logic [1:0]        last_opi;
    logic [GAIN_W-1:0] kc;
    logic [COV_W-1:0]  sm_x;
    logic [COV_W-1:0]  sm_y;
    logic [COV_W-1:0]  sm_sel;
    logic [63:0]       ppred_w;
    logic [63:0]       sum_w;
    logic [32:0]       diff_w;
    logic [32:0]       magw;
    logic [56:0]       dsum;
    logic [32:0]       delta;
    logic [33:0]       est_w;

    function automatic logic [COV_W-1:0] sq_to_cov(input logic [63:0] sq);
        logic [63:0] tmp;
        tmp = sq << SQ_LSH;
        if (SQ_RSH > 0) begin
            return rnd_shift({32'b0, sq}, SQ_RSH);
        end else if (SQ_LSH > 0) begin
            if (sq > {1'b0, MAX63 >> SQ_LSH}) begin
                return MAX63;
            end
            return tmp[COV_W-1:0];
        end
        return sq[63] ? MAX63 : sq[COV_W-1:0];
    endfunction

    skf_mac u_mac (
        .aclk (aclk),
        .ctrl (mac_ctrl),
        .op_a (mac_a),
        .op_b (mac_b),
        .acc  (acc)
    );

    skf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign cfg_ready = 1'b1;

    // operand selection for the shared multiplier
    always_comb begin
        kc     = GAIN_ONE - gain_reg;
        sm_x   = (grp_reg == G_SM1) ? var_reg : r_reg;
        sm_y   = (grp_reg == G_SM1) ? sqc_reg : var_reg;
        sm_sel = opi_reg[1] ? sm_y : sm_x;
        mac_a  = mag_reg;
        mac_b  = {7'b0, gain_reg};
        mac_ctrl.hi = 1'b0;
        last_opi    = 2'd0;
        case (grp_reg)
            G_DELTA: begin
                mac_a = mag_reg;
                mac_b = {7'b0, gain_reg};
            end
            G_COV: begin
                mac_a = opi_reg[0] ? {1'b0, ppred_reg[62:32]} : ppred_reg[31:0];
                mac_b = {7'b0, kc};
                mac_ctrl.hi = opi_reg[0];
                last_opi    = 2'd1;
            end
            G_SQ: begin
                mac_a = mag_reg;
                mac_b = mag_reg;
            end
            G_SM1, G_SM2: begin
                mac_a = opi_reg[0] ? {1'b0, sm_sel[62:32]} : sm_sel[31:0];
                mac_b = opi_reg[1] ? W_NEW : W_OLD;
                mac_ctrl.hi = opi_reg[0];
                last_opi    = 2'd3;
            end
            default: begin
                mac_a = mag_reg;
            end
        endcase
        mac_ctrl.issue = (state_reg == S_MUL);
        mac_ctrl.clear = (opi_reg == 2'd0);
        mac_ctrl.accum = (state_reg == S_ACC);
    end

    always_comb begin
        state_next    = state_reg;
        grp_next      = grp_reg;
        opi_next      = opi_reg;
        init_est_next = init_est_reg;
        init_cov_next = init_cov_reg;
        q_next        = q_reg;
        meas_next     = meas_reg;
        adapt_next    = adapt_reg;
        limit_next    = limit_reg;
        est_next      = est_reg;
        cov_next      = cov_reg;
        r_next        = r_reg;
        var_next      = var_reg;
        gain_next     = gain_reg;
        err_flag_next = err_flag_reg;
        err_code_next = err_code_reg;
        ppred_next    = ppred_reg;
        mag_next      = mag_reg;
        neg_next      = neg_reg;
        sqc_next      = sqc_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;

        div_req.start = 1'b0;
        div_req.num   = ppred_reg;
        div_req.den   = {1'b0, ppred_reg} + {1'b0, r_reg};

        ppred_w = {1'b0, cov_reg} + {1'b0, q_reg};
        sum_w   = {1'b0, ppred_reg} + {1'b0, r_reg};
        diff_w  = {s_data.value[31], s_data.value} - {est_reg[31], est_reg};
        magw    = diff_w[32] ? (33'd0 - diff_w) : diff_w;
        dsum    = acc[56:0] + (57'(1) << (GAIN_FRAC - 1));
        delta   = dsum[56:GAIN_FRAC];
        est_w   = neg_reg ? ({{2{est_reg[31]}}, est_reg} - {1'b0, delta})
                          : ({{2{est_reg[31]}}, est_reg} + {1'b0, delta});

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_data.req_type == REQ_RESTART) begin
                        est_next      = s_data.value;
                        gain_next     = '0;
                        err_flag_next = 1'b0;
                        err_code_next = ERR_OK;
                        state_next    = S_OUT;
                    end else begin
                        mag_next   = magw[31:0];
                        neg_next   = diff_w[32];
                        state_next = S_PRED;
                    end
                end
            end
            S_PRED: begin
                if (ppred_w[63]) begin
                    err_flag_next = 1'b1;
                    err_code_next = ERR_OVERFLOW;
                    state_next    = S_OUT;
                end else begin
                    ppred_next = ppred_w[COV_W-1:0];
                    state_next = S_SUM;
                end
            end
            S_SUM: begin
                grp_next = G_DELTA;
                opi_next = 2'd0;
                if (sum_w == 64'd0) begin
                    gain_next  = '0;
                    state_next = S_MUL;
                end else if (r_reg == '0) begin
                    gain_next  = GAIN_ONE;
                    state_next = S_MUL;
                end else begin
                    div_req.start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    gain_next  = {1'b0, div_rsp.quot};
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                state_next = S_ACC;
            end
            S_ACC: begin
                if (opi_reg == last_opi) begin
                    state_next = S_FIN;
                end else begin
                    opi_next   = opi_reg + 2'd1;
                    state_next = S_MUL;
                end
            end
            S_FIN: begin
                opi_next   = 2'd0;
                state_next = S_MUL;
                case (grp_reg)
                    G_DELTA: begin
                        est_next = est_w[31:0];
                        grp_next = G_COV;
                    end
                    G_COV: begin
                        cov_next = rnd_shift(acc, GAIN_FRAC);
                        if (adapt_reg) begin
                            grp_next = G_SQ;
                        end else begin
                            state_next = S_CHK;
                        end
                    end
                    G_SQ: begin
                        sqc_next = sq_to_cov(acc[63:0]);
                        grp_next = G_SM1;
                    end
                    G_SM1: begin
                        var_next = rnd_shift(acc, W_FRAC);
                        grp_next = G_SM2;
                    end
                    default: begin
                        r_next     = rnd_shift(acc, W_FRAC);
                        state_next = S_CHK;
                    end
                endcase
            end
            S_CHK: begin
                if (cov_reg > limit_reg) begin
                    err_flag_next = 1'b1;
                    err_code_next = ERR_DIVERGED;
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                // hold until the output register frees
                if (!m_valid_reg || m_ready) begin
                    m_valid_next           = 1'b1;
                    m_data_next.estimate   = est_reg;
                    m_data_next.gain       = gain_reg;
                    m_data_next.covariance = cov_reg;
                    m_data_next.error_held = err_flag_reg;
                    m_data_next.error_code = err_code_reg;
                    state_next             = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_valid) begin
            unique case (cfg_index)
                REG_INIT_EST: begin
                    init_est_next = cfg_data[VAL_W-1:0];
                    est_next      = cfg_data[VAL_W-1:0];
                    cov_next      = init_cov_reg;
                    r_next        = meas_reg;
                    var_next      = meas_reg;
                    gain_next     = '0;
                    err_flag_next = 1'b0;
                    err_code_next = ERR_OK;
                end
                REG_INIT_COV: begin
                    init_cov_next = cfg_data;
                    est_next      = init_est_reg;
                    cov_next      = cfg_data;
                    r_next        = meas_reg;
                    var_next      = meas_reg;
                    gain_next     = '0;
                    err_flag_next = 1'b0;
                    err_code_next = ERR_OK;
                end
                REG_Q: begin
                    q_next = cfg_data;
                end
                REG_R: begin
                    meas_next = cfg_data;
                    r_next    = cfg_data;
                    var_next  = cfg_data;
                end
                REG_ADAPT: begin
                    adapt_next = cfg_data[0];
                end
                REG_LIMIT: begin
                    limit_next = cfg_data;
                end
                default: begin
                    // drop writes to unknown registers
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            grp_reg      <= G_DELTA;
            opi_reg      <= 2'd0;
            init_est_reg <= INIT_EST_RST;
            init_cov_reg <= INIT_COV_RST;
            q_reg        <= Q_RST;
            meas_reg     <= R_RST;
            adapt_reg    <= 1'b0;
            limit_reg    <= LIMIT_RST;
            est_reg      <= INIT_EST_RST;
            cov_reg      <= INIT_COV_RST;
            r_reg        <= R_RST;
            var_reg      <= R_RST;
            gain_reg     <= '0;
            err_flag_reg <= 1'b0;
            err_code_reg <= ERR_OK;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            grp_reg      <= grp_next;
            opi_reg      <= opi_next;
            init_est_reg <= init_est_next;
            init_cov_reg <= init_cov_next;
            q_reg        <= q_next;
            meas_reg     <= meas_next;
            adapt_reg    <= adapt_next;
            limit_reg    <= limit_next;
            est_reg      <= est_next;
            cov_reg      <= cov_next;
            r_reg        <= r_next;
            var_reg      <= var_next;
            gain_reg     <= gain_next;
            err_flag_reg <= err_flag_next;
            err_code_reg <= err_code_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ppred_reg  <= ppred_next;
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        sqc_reg    <= sqc_next;
        m_data_reg <= m_data_next;
    end

endmodule

// ===== hw/rtl/skf_mac.sv =====
// ----------------------------------------------------------------------------
// skf_mac
// Shared 32x32 multiplier with a registered product and a 96-bit accumulator.
// ----------------------------------------------------------------------------
module skf_mac (
    input  logic                      aclk,
    input  skf_pkg::mac_ctrl_t        ctrl,
    input  logic [31:0]               op_a,
    input  logic [31:0]               op_b,
    output logic [skf_pkg::ACC_W-1:0] acc
);
    import skf_pkg::*;

    logic [63:0]      prod_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] addend;

    assign addend = ctrl.hi ? ({32'b0, prod_reg} << 32) : {32'b0, prod_reg};
    assign acc    = acc_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.issue) begin
            prod_reg <= op_a * op_b;
        end
        if (ctrl.issue && ctrl.clear) begin
            acc_reg <= '0;
        end else if (ctrl.accum) begin
            acc_reg <= acc_reg + addend;
        end
    end

endmodule

// ===== hw/rtl/skf_div.sv =====
// ----------------------------------------------------------------------------
// skf_div
// Restoring divider, one quotient bit per cycle, for the fractional gain.
// ----------------------------------------------------------------------------
module skf_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  skf_pkg::div_req_t req,
    output skf_pkg::div_rsp_t rsp
);
    import skf_pkg::*;

    localparam int CNT_W = $clog2(GAIN_FRAC);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [63:0]          rem_reg;
    logic [63:0]          den_reg;
    logic [GAIN_FRAC-1:0] q_reg;
    logic [64:0]          rem2;
    logic [64:0]          diff;
    logic                 ge;

    assign rem2 = {rem_reg, 1'b0};
    assign diff = rem2 - {1'b0, den_reg};
    assign ge   = rem2 >= {1'b0, den_reg};

    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(GAIN_FRAC - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= {1'b0, req.num};
            den_reg <= req.den;
            q_reg   <= '0;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[63:0] : rem2[63:0];
            q_reg   <= {q_reg[GAIN_FRAC-2:0], ge};
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the scalar Kalman filter: a directed table of
// updates and restarts across register settings, then random sequences, all
// checked field by field against a bit-accurate filter model in the bench.
// ----------------------------------------------------------------------------
module tb_top;
    import skf_pkg::*;

    localparam int        N_RANDOM  = 1000;
    localparam longint    MAX_CYCLE = 2000000;
    localparam logic [62:0] M63     = 63'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct {
        logic       restart;
        logic [31:0] value;
        logic       typed;
        out_t       want;
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COV_W-1:0]     cfg_data = '0;

    // filter model state and registers
    logic [31:0] k_init_est;
    logic [62:0] k_init_cov, k_q, k_r_cfg, k_limit;
    logic        k_adapt;
    logic signed [63:0] k_est;
    logic [62:0] k_cov, k_r, k_var;
    logic [24:0] k_gain;
    logic        k_flag;
    logic [1:0]  k_code;

    out_t   result_fifo[$];
    logic   typed_fifo[$];
    out_t   typed_want_fifo[$];
    int     n_errors = 0;
    int     n_results = 0;
    int     n_updates = 0;
    int     n_restarts = 0;
    longint cycle = 0;
    logic   quiet_in = 1'b0;
    logic   quiet_out = 1'b0;

    always #6 aclk = ~aclk;

    scalar_kalman_filter i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always @(posedge aclk) begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE) begin
            $display("timeout at cycle %0d", cycle);
            $display("== FAIL ==");
            $finish;
        end
    end

    // (v + 2^(n-1)) >> n over 128 bits, saturated to 63 bits
    function automatic logic [62:0] round_sat(input logic [127:0] v, input int n);
        logic [127:0] s;
        s = (v + (128'(1) << (n - 1))) >> n;
        return (s > 128'(M63)) ? M63 : s[62:0];
    endfunction

    function automatic logic [62:0] blend(input logic [62:0] a, input logic [62:0] b);
        return round_sat(128'(a) * 128'd58982 + 128'(b) * 128'd6554, W_FRAC);
    endfunction

    function automatic logic [24:0] kalman_gain(input logic [62:0] pp, input logic [62:0] r);
        logic [63:0] s;
        logic [64:0] rem;
        logic [24:0] q;
        s = 64'(pp) + 64'(r);
        q = '0;
        if (s == 0) return '0;
        if (r == 0) return GAIN_ONE;
        rem = 65'(pp);
        for (int i = 0; i < GAIN_FRAC; i++) begin
            rem = {rem[63:0], 1'b0};
            q = {q[23:0], 1'b0};
            if (rem >= 65'(s)) begin
                rem = rem - 65'(s);
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    task automatic load_filter();
        k_est  = $signed(k_init_est);
        k_cov  = k_init_cov;
        k_r    = k_r_cfg;
        k_var  = k_r_cfg;
        k_gain = '0;
        k_flag = 1'b0;
        k_code = ERR_OK;
    endtask

    task automatic model_config(input logic [2:0] idx, input logic [62:0] d);
        case (idx)
            REG_INIT_EST: begin k_init_est = d[31:0]; load_filter(); end
            REG_INIT_COV: begin k_init_cov = d; load_filter(); end
            REG_Q:        k_q = d;
            REG_R: begin
                k_r_cfg = d; k_r = d; k_var = d;
            end
            REG_ADAPT:    k_adapt = d[0];
            REG_LIMIT:    k_limit = d;
            default: ;
        endcase
    endtask

    function automatic out_t filter_step(input logic restart, input logic [31:0] value);
        logic [63:0] pp;
        logic signed [63:0] z, diff;
        logic [63:0] mag, delta;
        logic [127:0] sq;
        out_t o;
        z = $signed(value);
        if (restart) begin
            k_est = z; k_gain = '0; k_flag = 1'b0; k_code = ERR_OK;
        end else begin
            pp = 64'(k_cov) + 64'(k_q);
            if (pp[63]) begin
                k_flag = 1'b1; k_code = ERR_OVERFLOW;
            end else begin
                k_gain = kalman_gain(pp[62:0], k_r);
                diff = z - k_est;
                mag = diff[63] ? -diff : diff;
                delta = (mag * 64'(k_gain) + 64'(GAIN_ONE >> 1)) >> GAIN_FRAC;
                k_est = diff[63] ? k_est - $signed(delta) : k_est + $signed(delta);
                k_cov = round_sat(128'(64'(GAIN_ONE) - 64'(k_gain)) * 128'(pp), GAIN_FRAC);
                if (k_adapt) begin
                    sq = 128'(mag) * 128'(mag);
                    k_var = blend(k_var, round_sat(sq, 2 * VALUE_FRAC - COV_FRAC));
                    k_r = blend(k_r, k_var);
                end
                if (k_cov > k_limit) begin
                    k_flag = 1'b1; k_code = ERR_DIVERGED;
                end
            end
        end
        o.estimate = k_est[31:0];
        o.gain = k_gain;
        o.covariance = k_cov;
        o.error_held = k_flag;
        o.error_code = k_code;
        return o;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        n_errors++;
        $display("mismatch %s at result %0d: got %h want %h", what, n_results, got, want);
    endtask

    task automatic check_field(input string what, input logic [63:0] got, input logic [63:0] want);
        if (got !== want) report(what, got, want);
    endtask

    // result side: random stall, compare each accepted item
    always @(posedge aclk) begin
        out_t w;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (result_fifo.size() == 0) begin
                    report("unexpected item", 64'(m_data.estimate), 0);
                end else begin
                    w = result_fifo.pop_front();
                    if (typed_fifo.pop_front()) begin
                        if (typed_want_fifo.pop_front() !== w)
                            report("typed row vs model", 0, 0);
                    end
                    check_field("estimate", 64'(m_data.estimate), 64'(w.estimate));
                    check_field("gain", 64'(m_data.gain), 64'(w.gain));
                    check_field("covariance", 64'(m_data.covariance), 64'(w.covariance));
                    check_field("error_held", 64'(m_data.error_held), 64'(w.error_held));
                    check_field("error_code", 64'(m_data.error_code), 64'(w.error_code));
                end
                n_results++;
            end
            m_ready <= quiet_out || ($urandom_range(99) >= 16);
        end
    end

    task automatic send_item(input logic restart, input logic [31:0] value,
                             input logic typed, input out_t want);
        @(posedge aclk);
        while (!quiet_in && $urandom_range(99) < 16) @(posedge aclk);
        s_valid <= 1'b1;
        s_data.req_type <= restart;
        s_data.value <= value;
        do @(posedge aclk); while (!s_ready);
        s_valid <= 1'b0;
        result_fifo.push_back(filter_step(restart, value));
        typed_fifo.push_back(typed);
        if (typed) typed_want_fifo.push_back(want);
        if (restart) n_restarts++; else n_updates++;
    endtask

    task automatic drain();
        while (result_fifo.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [62:0] d);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        model_config(idx, d);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(65536 * 8) - 65536 * 4;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [62:0] rand_noise();
        case ($urandom_range(5))
            0: return '0;
            1: return 63'({$urandom, $urandom});
            default: return 63'($urandom_range(1 << 26));
        endcase
    endfunction

    initial begin
        stim_row_t rows[$];
        out_t w;
        k_init_est = INIT_EST_RST; k_init_cov = INIT_COV_RST; k_q = Q_RST;
        k_r_cfg = R_RST; k_adapt = 1'b0; k_limit = LIMIT_RST;
        load_filter();

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // restart after reset: estimate loads, gain zero, covariance as reset
        w = '{estimate: 32'h8000_0000, gain: '0, covariance: INIT_COV_RST,
              error_held: 1'b0, error_code: ERR_OK};
        rows.push_back('{1'b1, 32'h8000_0000, 1'b1, w});
        rows.push_back('{1'b0, 32'h7FFF_FFFF, 1'b0, '0});
        rows.push_back('{1'b0, 32'h8000_0000, 1'b0, '0});
        rows.push_back('{1'b1, 32'h7FFF_FFFF, 1'b0, '0});
        rows.push_back('{1'b0, 32'h0000_0000, 1'b0, '0});
        rows.push_back('{1'b0, 32'hFFFF_FFFF, 1'b0, '0});
        foreach (rows[i]) send_item(rows[i].restart, rows[i].value, rows[i].typed, rows[i].want);
        drain();

        // zero noise gives unit gain; adaptive mode on
        write_reg(REG_R, '0);
        write_reg(REG_ADAPT, 63'd1);
        for (int i = 0; i < 4; i++) send_item(1'b0, rand_value(), 1'b0, '0);
        drain();
        // zero covariance, zero noise and zero R: zero denominator
        write_reg(REG_Q, '0);
        write_reg(REG_INIT_COV, '0);
        write_reg(REG_R, '0);
        w = '{estimate: 32'h0, gain: '0, covariance: '0, error_held: 1'b0, error_code: ERR_OK};
        send_item(1'b0, 32'h0, 1'b1, w);
        send_item(1'b0, 32'h1234_5678, 1'b0, '0);
        drain();
        // prediction overflow: state kept, error code set
        write_reg(REG_INIT_EST, 63'h0001_0000);
        write_reg(REG_INIT_COV, M63);
        write_reg(REG_Q, 63'd1);
        w = '{estimate: 32'h0001_0000, gain: '0, covariance: M63,
              error_held: 1'b1, error_code: ERR_OVERFLOW};
        send_item(1'b0, 32'h7FFF_FFFF, 1'b1, w);
        send_item(1'b1, 32'h0000_0005, 1'b0, '0);
        drain();
        // divergence against a zero limit, sticky until restart
        write_reg(REG_INIT_COV, 63'd16777216);
        write_reg(REG_Q, Q_RST);
        write_reg(REG_R, R_RST);
        write_reg(REG_LIMIT, '0);
        send_item(1'b0, 32'h0002_0000, 1'b0, '0);
        send_item(1'b0, 32'h8000_0000, 1'b0, '0);
        send_item(1'b1, 32'h0, 1'b0, '0);
        drain();

        // random phases, each with fresh settings
        for (int ph = 0; ph < 10; ph++) begin
            quiet_in = (ph == 3);
            quiet_out = (ph == 3);
            write_reg(REG_INIT_EST, 63'(rand_value()));
            write_reg(REG_INIT_COV, ph == 9 ? M63 - 63'd5 : rand_noise());
            write_reg(REG_Q, ph == 9 ? 63'd1 : rand_noise());
            write_reg(REG_R, rand_noise());
            write_reg(REG_ADAPT, 63'($urandom_range(1)));
            write_reg(REG_LIMIT, $urandom_range(3) == 0 ? 63'(rand_noise()) :
                      ($urandom_range(1) ? M63 : LIMIT_RST));
            if ($urandom_range(1)) write_reg(REG_UNUSED, 63'({$urandom, $urandom}));
            for (int i = 0; i < N_RANDOM / 10; i++)
                send_item($urandom_range(9) == 0, rand_value(), 1'b0, '0);
            drain();
        end
        quiet_in = 1'b0;
        quiet_out = 1'b0;

        $display("covered %0d updates and %0d restarts, %0d results checked",
                 n_updates, n_restarts, n_results);
        $display("register phases included zero noise, overflow and divergence");
        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// ===== files.f =====
hw/rtl/skf_pkg.sv
hw/rtl/skf_mac.sv
hw/rtl/skf_div.sv
hw/rtl/scalar_kalman_filter.sv
tb/tb_top.sv
